// ----- hw/rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps

package bpa_pkg;

  // Field widths of the item channels.
  localparam int OP_W   = 2;
  localparam int CNT_W  = 13;
  localparam int IDX_W  = 12;
  localparam int ORD_W  = 4;
  localparam int STAT_W = 2;
  localparam int TBC_W  = 3;

  // Defaults of the top-level parameters.
  localparam int TOP_ORDER_DEF  = 10;
  localparam int PAGE_COUNT_DEF = 4096;

  // Reset value of the top block count register.
  localparam logic [TBC_W-1:0] TBC_RESET = 3'd4;

  // Order code of a page that heads no block.
  localparam logic [ORD_W-1:0] NO_BLOCK = 4'd15;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_TBC = 1'b0;

  // Per-page marks held in the page store.
  typedef struct packed {
    logic             used;
    logic [ORD_W-1:0] order;
  } meta_t;

endpackage

// ----- hw/rtl/bpa_in_if.sv -----
`timescale 1ns / 1ps

interface bpa_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::OP_W-1:0]   op;
  logic [bpa_pkg::CNT_W-1:0]  page_count;
  logic [bpa_pkg::IDX_W-1:0]  page_index;

  modport source (output valid, output op, output page_count, output page_index,
                  input ready);
  modport sink (input valid, input op, input page_count, input page_index,
                output ready);
endinterface

// ----- hw/rtl/bpa_out_if.sv -----
`timescale 1ns / 1ps

interface bpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpa_pkg::STAT_W-1:0]  status;
  logic [bpa_pkg::IDX_W-1:0]   granted_index;
  logic [bpa_pkg::ORD_W-1:0]   granted_order;

  modport source (output valid, output status, output granted_index,
                  output granted_order, input ready);
  modport sink (input valid, input status, input granted_index,
                input granted_order, output ready);
endinterface

// ----- hw/rtl/bpa_ram.sv -----
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/bpa_core.sv -----
`timescale 1ns / 1ps

module bpa_core #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bpa_pkg::TBC_W-1:0] top_block_count,
  bpa_in_if.sink                    in_ch,
  bpa_out_if.source                 out_ch
);

  localparam int AW      = $clog2(PAGE_COUNT);
  localparam int FCW     = AW + 1;
  localparam int NUM_ORD = TOP_ORDER + 1;
  localparam int OW      = bpa_pkg::ORD_W;
  localparam int TW      = bpa_pkg::TBC_W;
  localparam int XW      = bpa_pkg::IDX_W;
  localparam int PCW     = AW + 1;
  localparam int CW      = (PCW > XW) ? PCW : XW;
  localparam int FIT     = PAGE_COUNT >> TOP_ORDER;
  localparam int FIT_CAP = (FIT > 7) ? 7 : FIT;
  localparam logic [OW-1:0] TOP_O = OW'(TOP_ORDER);
  localparam logic [CW-1:0] PAGES = CW'(PAGE_COUNT);
  localparam logic [AW-1:0] LAST  = AW'(PAGE_COUNT - 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CLR     = 18'h00002,
    S_INIT    = 18'h00004,
    S_SRCH    = 18'h00008,
    S_SPLIT   = 18'h00010,
    S_RM_GO   = 18'h00020,
    S_RM_LNK  = 18'h00040,
    S_RM_SELF = 18'h00080,
    S_PS_GO   = 18'h00100,
    S_PS_LNK  = 18'h00200,
    S_PS_FIN  = 18'h00400,
    S_F_WT    = 18'h00800,
    S_F_BUD   = 18'h01000,
    S_F_BWT   = 18'h02000,
    S_F_MRG   = 18'h04000,
    S_F_MRG2  = 18'h08000,
    S_F_END   = 18'h10000,
    S_RESP    = 18'h20000
  } state_t;

  state_t st_r, st_nxt;

  logic [AW-1:0]  clr_r, clr_nxt;
  logic           init_r, init_nxt;
  logic [TW-1:0]  i_r, i_nxt;
  logic [AW-1:0]  head_r [NUM_ORD];
  logic [AW-1:0]  head_nxt [NUM_ORD];
  logic [FCW-1:0] cnt_r [NUM_ORD];
  logic [FCW-1:0] cnt_nxt [NUM_ORD];
  logic           ov_r, ov_nxt;

  logic [bpa_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [OW-1:0]              lo_r, lo_nxt;
  logic [OW-1:0]              ord_r, ord_nxt;
  logic [AW-1:0]              p_r, p_nxt;
  logic [AW-1:0]              q_r, q_nxt;
  logic [AW-1:0]              n_r, n_nxt;
  logic [bpa_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [XW-1:0]              gidx_r, gidx_nxt;
  logic [OW-1:0]              gord_r, gord_nxt;
  logic [bpa_pkg::STAT_W-1:0] ostat_r, ostat_nxt;
  logic [XW-1:0]              oidx_r, oidx_nxt;
  logic [OW-1:0]              oord_r, oord_nxt;

  logic [AW-1:0]     m_addr, nx_addr, pv_addr;
  logic              m_we, nx_we, pv_we;
  bpa_pkg::meta_t    m_wd, m_rd;
  logic [AW-1:0]     nx_wd, nx_rd, pv_wd, pv_rd;

  logic [bpa_pkg::CNT_W-1:0] cm1;
  logic [OW-1:0]             lo_c;
  logic [TW-1:0]             n_lim;

  // Page marks and the two link stores.
  bpa_ram #(.WIDTH($bits(bpa_pkg::meta_t)), .DEPTH(PAGE_COUNT)) u_meta (
    .clk(clk), .addr(m_addr), .we(m_we), .wdata(m_wd), .rdata(m_rd)
  );
  bpa_ram #(.WIDTH(AW), .DEPTH(PAGE_COUNT)) u_next (
    .clk(clk), .addr(nx_addr), .we(nx_we), .wdata(nx_wd), .rdata(nx_rd)
  );
  bpa_ram #(.WIDTH(AW), .DEPTH(PAGE_COUNT)) u_prev (
    .clk(clk), .addr(pv_addr), .we(pv_we), .wdata(pv_wd), .rdata(pv_rd)
  );

  // Order of an allocate request: bit length of (count - 1), or zero for a count of one or less.
  always_comb begin
    cm1  = in_ch.page_count - bpa_pkg::CNT_W'(1);
    lo_c = '0;
    if (in_ch.page_count > bpa_pkg::CNT_W'(1)) begin
      for (int k = 0; k < bpa_pkg::CNT_W; k++) begin
        if (cm1[k]) begin
          lo_c = OW'(k + 1);
        end
      end
    end
  end

  // Number of top blocks that init places, limited to what fits.
  assign n_lim = (top_block_count < TW'(FIT_CAP)) ? top_block_count : TW'(FIT_CAP);

  assign in_ch.ready          = (st_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = ostat_r;
  assign out_ch.granted_index = oidx_r;
  assign out_ch.granted_order = oord_r;

  // Sequencer: every step drives at most one access per store.
  always_comb begin
    logic [CW-1:0] bud;
    logic [AW-1:0] base;
    bud       = CW'(p_r) ^ (CW'(1) << ord_r);
    base      = AW'(32'(i_r) << TOP_ORDER);
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    init_nxt  = init_r;
    i_nxt     = i_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    op_nxt    = op_r;
    lo_nxt    = lo_r;
    ord_nxt   = ord_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    stat_nxt  = stat_r;
    gidx_nxt  = gidx_r;
    gord_nxt  = gord_r;
    ostat_nxt = ostat_r;
    oidx_nxt  = oidx_r;
    oord_nxt  = oord_r;
    m_addr    = q_r;
    m_we      = 1'b0;
    m_wd      = '{used: 1'b0, order: bpa_pkg::NO_BLOCK};
    nx_addr   = q_r;
    nx_we     = 1'b0;
    nx_wd     = q_r;
    pv_addr   = q_r;
    pv_we     = 1'b0;
    pv_wd     = q_r;

    // The waiting result leaves when taken.
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.op;
          p_nxt    = AW'(in_ch.page_index);
          stat_nxt = bpa_pkg::ST_DONE;
          gidx_nxt = '0;
          gord_nxt = '0;
          case (in_ch.op)
            bpa_pkg::OP_ALLOC: begin
              lo_nxt  = lo_c;
              ord_nxt = lo_c;
              if (lo_c > TOP_O) begin
                stat_nxt = bpa_pkg::ST_NOMEM;
                st_nxt   = S_RESP;
              end else begin
                st_nxt = S_SRCH;
              end
            end
            bpa_pkg::OP_FREE: begin
              if (CW'(in_ch.page_index) >= PAGES) begin
                stat_nxt = bpa_pkg::ST_BADFREE;
                st_nxt   = S_RESP;
              end else begin
                m_addr = AW'(in_ch.page_index);
                st_nxt = S_F_WT;
              end
            end
            bpa_pkg::OP_INIT: begin
              clr_nxt  = '0;
              init_nxt = 1'b1;
              for (int k = 0; k < NUM_ORD; k++) begin
                head_nxt[k] = '0;
                cnt_nxt[k]  = '0;
              end
              st_nxt = S_CLR;
            end
            default: st_nxt = S_RESP;
          endcase
        end
      end

      // Clearing pass over the page marks.
      S_CLR: begin
        m_we    = 1'b1;
        m_addr  = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST) begin
          init_nxt = 1'b0;
          i_nxt    = '0;
          st_nxt   = init_r ? S_INIT : S_IDLE;
        end
      end

      S_INIT: begin
        if (i_r < n_lim) begin
          q_nxt   = base;
          m_we    = 1'b1;
          m_addr  = base;
          m_wd    = '{used: 1'b0, order: TOP_O};
          ord_nxt = TOP_O;
          i_nxt   = i_r + TW'(1);
          st_nxt  = S_PS_GO;
        end else begin
          st_nxt = S_RESP;
        end
      end

      // One order per cycle, from the request order upward.
      S_SRCH: begin
        if (ord_r > TOP_O) begin
          stat_nxt = bpa_pkg::ST_NOMEM;
          st_nxt   = S_RESP;
        end else if (cnt_r[ord_r] != '0) begin
          p_nxt  = head_r[ord_r];
          q_nxt  = head_r[ord_r];
          st_nxt = S_RM_GO;
        end else begin
          ord_nxt = ord_r + OW'(1);
        end
      end

      // Split off the upper half, or grant the block.
      S_SPLIT: begin
        if (ord_r > lo_r) begin
          ord_nxt = ord_r - OW'(1);
          q_nxt   = p_r + (AW'(1) << (ord_r - OW'(1)));
          m_we    = 1'b1;
          m_addr  = q_nxt;
          m_wd    = '{used: 1'b0, order: ord_r - OW'(1)};
          st_nxt  = S_PS_GO;
        end else begin
          m_we     = 1'b1;
          m_addr   = p_r;
          m_wd     = '{used: 1'b1, order: lo_r};
          gidx_nxt = XW'(p_r);
          gord_nxt = lo_r;
          st_nxt   = S_RESP;
        end
      end

      // Unlink q from list ord.
      S_RM_GO: begin
        if (cnt_r[ord_r] == '0) begin
          st_nxt = (op_r == bpa_pkg::OP_ALLOC) ? S_SPLIT : S_F_MRG;
        end else begin
          st_nxt = S_RM_LNK;
        end
      end

      S_RM_LNK: begin
        cnt_nxt[ord_r] = cnt_r[ord_r] - FCW'(1);
        if (cnt_r[ord_r] != FCW'(1)) begin
          if (head_r[ord_r] == q_r) begin
            head_nxt[ord_r] = nx_rd;
          end
          nx_we   = 1'b1;
          nx_addr = pv_rd;
          nx_wd   = nx_rd;
          pv_we   = 1'b1;
          pv_addr = nx_rd;
          pv_wd   = pv_rd;
        end
        st_nxt = S_RM_SELF;
      end

      S_RM_SELF: begin
        nx_we  = 1'b1;
        pv_we  = 1'b1;
        st_nxt = (op_r == bpa_pkg::OP_ALLOC) ? S_SPLIT : S_F_MRG;
      end

      // Push q right after the head of list ord.
      S_PS_GO: begin
        if (cnt_r[ord_r] == '0) begin
          head_nxt[ord_r] = q_r;
          cnt_nxt[ord_r]  = cnt_r[ord_r] + FCW'(1);
          nx_we = 1'b1;
          pv_we = 1'b1;
          case (op_r)
            bpa_pkg::OP_ALLOC: st_nxt = S_SPLIT;
            bpa_pkg::OP_INIT:  st_nxt = S_INIT;
            default:           st_nxt = S_RESP;
          endcase
        end else begin
          nx_addr = head_r[ord_r];
          st_nxt  = S_PS_LNK;
        end
      end

      S_PS_LNK: begin
        n_nxt  = nx_rd;
        nx_we  = 1'b1;
        nx_wd  = nx_rd;
        pv_we  = 1'b1;
        pv_wd  = head_r[ord_r];
        st_nxt = S_PS_FIN;
      end

      S_PS_FIN: begin
        nx_we   = 1'b1;
        nx_addr = head_r[ord_r];
        pv_we   = 1'b1;
        pv_addr = n_r;
        cnt_nxt[ord_r] = cnt_r[ord_r] + FCW'(1);
        case (op_r)
          bpa_pkg::OP_ALLOC: st_nxt = S_SPLIT;
          bpa_pkg::OP_INIT:  st_nxt = S_INIT;
          default:           st_nxt = S_RESP;
        endcase
      end

      // Check the freed page and clear its in-use mark.
      S_F_WT: begin
        if (!m_rd.used || (m_rd.order > TOP_O)) begin
          stat_nxt = bpa_pkg::ST_BADFREE;
          st_nxt   = S_RESP;
        end else begin
          ord_nxt = m_rd.order;
          m_we    = 1'b1;
          m_addr  = p_r;
          m_wd    = '{used: 1'b0, order: m_rd.order};
          st_nxt  = S_F_BUD;
        end
      end

      S_F_BUD: begin
        if ((ord_r >= TOP_O) || (bud >= PAGES)) begin
          st_nxt = S_F_END;
        end else begin
          q_nxt  = AW'(bud);
          m_addr = AW'(bud);
          st_nxt = S_F_BWT;
        end
      end

      S_F_BWT: begin
        if ((m_rd.order != ord_r) || m_rd.used) begin
          st_nxt = S_F_END;
        end else begin
          st_nxt = S_RM_GO;
        end
      end

      S_F_MRG: begin
        m_we   = 1'b1;
        st_nxt = S_F_MRG2;
      end

      S_F_MRG2: begin
        m_we    = 1'b1;
        m_addr  = p_r;
        p_nxt   = p_r & q_r;
        ord_nxt = ord_r + OW'(1);
        st_nxt  = S_F_BUD;
      end

      S_F_END: begin
        m_we     = 1'b1;
        m_addr   = p_r;
        m_wd     = '{used: 1'b0, order: ord_r};
        q_nxt    = p_r;
        gord_nxt = ord_r;
        st_nxt   = S_PS_GO;
      end

      // Hand the result to the output register once it is free or being taken.
      S_RESP: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          ostat_nxt = stat_r;
          oidx_nxt  = gidx_r;
          oord_nxt  = gord_r;
          st_nxt    = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      init_r <= 1'b0;
      i_r    <= '0;
      ov_r   <= 1'b0;
      for (int k = 0; k < NUM_ORD; k++) begin
        head_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      init_r <= init_nxt;
      i_r    <= i_nxt;
      ov_r   <= ov_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    lo_r    <= lo_nxt;
    ord_r   <= ord_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    n_r     <= n_nxt;
    stat_r  <= stat_nxt;
    gidx_r  <= gidx_nxt;
    gord_r  <= gord_nxt;
    ostat_r <= ostat_nxt;
    oidx_r  <= oidx_nxt;
    oord_r  <= oord_nxt;
  end

`ifndef SYNTHESIS
  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (st_r != S_IDLE))
    else $error("accepted item did not start work");

  // Unlinking only happens on a non-empty list.
  a_rm_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RM_LNK) |-> (cnt_r[ord_r] != '0))
    else $error("unlink from an empty list");

  // A successful result never carries an order above the top.
  a_resp_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_RESP) && (stat_r == bpa_pkg::ST_DONE)) |-> (gord_r <= TOP_O))
    else $error("result order above top order");

  // A result is loaded only when the output register is free or drains.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(ostat_r))
    else $error("waiting result was overwritten");
`endif

endmodule

// ----- hw/rtl/buddy_page_allocator.sv -----
`timescale 1ns / 1ps

// Buddy page allocator over PAGE_COUNT pages with block orders 0..TOP_ORDER.
// Items are handled one at a time by a small sequencer that drives one
// access per cycle into each of three single-port stores (page marks, next
// links, previous links); a new item is taken while the previous result
// still waits on the output. After reset, and on every init item, a
// clearing pass writes the page marks of all PAGE_COUNT pages (4096 by
// default), during which no item is accepted; init then places the top
// blocks one by one. An allocate item searches the orders upward from the
// request order and splits the block it finds; a request above the top
// order, or a search that finds no block, ends in ST_NOMEM. A free item
// merges with its free buddy step by step and then pushes the block; a
// rejected free ends in ST_BADFREE. Results wait in an output register
// until taken.
module buddy_page_allocator #(
  parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [bpa_pkg::TBC_W-1:0] tbc_r, tbc_nxt;
  logic                      wr_en;

  // Configuration register write and readback.
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    tbc_nxt = tbc_r;
    if (wr_en && (cfg_paddr[2] == bpa_pkg::REG_TBC)) begin
      tbc_nxt = cfg_pwdata[bpa_pkg::TBC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbc_r <= bpa_pkg::TBC_RESET;
    end else begin
      tbc_r <= tbc_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == bpa_pkg::REG_TBC) ?
                      {{(32 - bpa_pkg::TBC_W){1'b0}}, tbc_r} : 32'd0;

  bpa_core #(.TOP_ORDER(TOP_ORDER), .PAGE_COUNT(PAGE_COUNT)) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .top_block_count (tbc_r),
    .in_ch           (in_ch),
    .out_ch          (out_ch)
  );

endmodule

// ----- tb/sv/buddy_page_allocator_tb.sv -----
`timescale 1ns / 1ps

module buddy_page_allocator_tb;

  localparam int TOP    = 10;
  localparam int NPAGES = 4096;
  localparam int NORD   = TOP + 1;
  localparam int OPW    = bpa_pkg::OP_W;
  localparam int CNTW   = bpa_pkg::CNT_W;
  localparam int IDXW   = bpa_pkg::IDX_W;
  localparam int ORDW   = bpa_pkg::ORD_W;
  localparam int STATW  = bpa_pkg::STAT_W;

  typedef struct packed {
    logic [STATW-1:0] status;
    logic [IDXW-1:0]  granted_index;
    logic [ORDW-1:0]  granted_order;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bpa_in_if  in_ch ();
  bpa_out_if out_ch ();

  buddy_page_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // Predictor state: page marks, circular free lists and the register copy.
  int pg_order [NPAGES];
  int pg_used  [NPAGES];
  int nxt      [NPAGES];
  int prv      [NPAGES];
  int head     [NORD];
  int fcount   [NORD];
  int tbc_shadow;

  grant_t pending_grants[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  // Pages currently handed out, used to build well-formed free items.
  int     held_pages[$];

  function automatic void clear_store();
    for (int i = 0; i < NPAGES; i++) begin
      pg_order[i] = int'(bpa_pkg::NO_BLOCK);
      pg_used[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int o = 0; o < NORD; o++) begin
      head[o] = 0;
      fcount[o] = 0;
    end
  endfunction

  function automatic void push_block(int o, int p);
    int h, n;
    if (fcount[o] == 0) begin
      head[o] = p;
      nxt[p] = p;
      prv[p] = p;
    end else begin
      h = head[o];
      n = nxt[h];
      nxt[p] = n;
      prv[p] = h;
      prv[n] = p;
      nxt[h] = p;
    end
    fcount[o]++;
  endfunction

  function automatic void unlink_block(int o, int p);
    int n, v;
    n = nxt[p];
    v = prv[p];
    if (fcount[o] == 0) return;
    fcount[o]--;
    if (fcount[o] != 0) begin
      if (head[o] == p) head[o] = n;
      nxt[v] = n;
      prv[n] = v;
    end
    nxt[p] = p;
    prv[p] = p;
  endfunction

  // Works out the result of one item and updates the predictor state.
  function automatic grant_t predict_grant(logic [OPW-1:0] op, int cnt, int pidx);
    grant_t g;
    int lo, hi, p, q, o, b, n;
    g = '0;
    if (op == bpa_pkg::OP_INIT) begin
      n = (tbc_shadow < NPAGES / 1024) ? tbc_shadow : NPAGES / 1024;
      clear_store();
      for (int i = 0; i < n; i++) begin
        pg_order[i << TOP] = TOP;
        push_block(TOP, i << TOP);
      end
    end else if (op == bpa_pkg::OP_ALLOC) begin
      lo = 0;
      while (lo < 13 && (1 << lo) < cnt) lo++;
      g.status = bpa_pkg::ST_NOMEM;
      if (lo <= TOP) begin
        for (hi = lo; hi <= TOP; hi++) begin
          if (fcount[hi] != 0) begin
            p = head[hi];
            unlink_block(hi, p);
            while (hi > lo) begin
              hi--;
              q = p + (1 << hi);
              pg_order[q] = hi;
              push_block(hi, q);
            end
            pg_order[p] = lo;
            pg_used[p] = 1;
            g.status = bpa_pkg::ST_DONE;
            g.granted_index = IDXW'(p);
            g.granted_order = ORDW'(lo);
            held_pages.push_back(p);
            break;
          end
        end
      end
    end else if (op == bpa_pkg::OP_FREE) begin
      if (pg_used[pidx] == 0 || pg_order[pidx] > TOP) begin
        g.status = bpa_pkg::ST_BADFREE;
      end else begin
        p = pidx;
        o = pg_order[p];
        pg_used[p] = 0;
        while (o < TOP) begin
          b = p ^ (1 << o);
          if (b >= NPAGES || pg_order[b] != o || pg_used[b] != 0) break;
          unlink_block(o, b);
          pg_order[b] = int'(bpa_pkg::NO_BLOCK);
          pg_order[p] = int'(bpa_pkg::NO_BLOCK);
          p = p & b;
          o++;
        end
        pg_order[p] = o;
        push_block(o, p);
        g.granted_order = ORDW'(o);
      end
    end
    return g;
  endfunction

  // Sends one item and records its expected result on acceptance.
  task automatic send_item(logic [OPW-1:0] op, int cnt, int pidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.page_count <= CNTW'(cnt);
    in_ch.page_index <= IDXW'(pidx);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_grants.push_back(predict_grant(op, cnt, pidx));
  endtask

  task automatic write_tbc(int value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * bpa_pkg::REG_TBC);
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tbc_shadow = value & 7;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Frees a page the allocator handed out, picked at random.
  task automatic free_held();
    int k;
    int p;
    k = $urandom_range(held_pages.size() - 1);
    p = held_pages[k];
    held_pages.delete(k);
    send_item(bpa_pkg::OP_FREE, $urandom, p);
  endtask

  // Result checker with random backpressure.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.granted_index !== want.granted_index) begin
          $error("granted_index: expected %0d, got %0d", want.granted_index,
                 out_ch.granted_index);
          errors++;
        end
        if (out_ch.granted_order !== want.granted_order) begin
          $error("granted_order: expected %0d, got %0d", want.granted_order,
                 out_ch.granted_order);
          errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Extremes of the fields and every special case.
  task automatic test_directed();
    held_pages.delete();
    send_item(bpa_pkg::OP_INIT, 0, 0);
    send_item(bpa_pkg::OP_ALLOC, 0, 0);
    send_item(bpa_pkg::OP_ALLOC, 1, 0);
    send_item(bpa_pkg::OP_ALLOC, 3, 0);
    send_item(bpa_pkg::OP_ALLOC, 1024, 0);
    send_item(bpa_pkg::OP_ALLOC, 1025, 0);
    send_item(bpa_pkg::OP_ALLOC, 8191, 0);
    send_item(bpa_pkg::OP_FREE, 0, 4095);
    send_item(bpa_pkg::OP_FREE, 0, 1);
    send_item(bpa_pkg::OP_FREE, 0, 0);
    send_item(bpa_pkg::OP_FREE, 0, 0);
    send_item(bpa_pkg::OP_FREE, 0, 2);
    send_item(bpa_pkg::OP_FREE, 0, 4);
    send_item(bpa_pkg::OP_NOP, 8191, 4095);
    for (int i = 0; i < 4; i++) send_item(bpa_pkg::OP_ALLOC, 1000, 0);
    send_item(bpa_pkg::OP_ALLOC, 1, 0);
    held_pages.delete();
    for (int i = 0; i < 4; i++) send_item(bpa_pkg::OP_FREE, 0, 3072 - 1024 * i);
    wait_drained();
  endtask

  // Mostly well-formed allocate and free traffic with some noise.
  task automatic test_random(int items, int tbc);
    int r;
    write_tbc(tbc);
    held_pages.delete();
    send_item(bpa_pkg::OP_INIT, $urandom, $urandom);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if ($urandom_range(9) == 0) begin
          send_item(bpa_pkg::OP_ALLOC, $urandom_range(8191), 0);
        end else begin
          send_item(bpa_pkg::OP_ALLOC, $urandom_range(1, 1 << $urandom_range(8)),
                    $urandom);
        end
      end else if (r < 88 && held_pages.size() != 0) begin
        free_held();
      end else if (r < 95) begin
        send_item(bpa_pkg::OP_FREE, $urandom, $urandom_range(4095));
      end else if (r < 98) begin
        send_item(bpa_pkg::OP_NOP, $urandom, $urandom);
      end else begin
        held_pages.delete();
        send_item(bpa_pkg::OP_INIT, $urandom, $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.page_count = '0;
    in_ch.page_index = '0;
    out_ch.ready = 1'b0;
    clear_store();
    tbc_shadow = int'(bpa_pkg::TBC_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_tbc(7);
    send_item(bpa_pkg::OP_INIT, 0, 0);
    send_item(bpa_pkg::OP_ALLOC, 4096, 0);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(75, 0);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(75, 1);
    send_idle_pct = 78; recv_stall_pct = 0;  test_random(75, 4);
    send_idle_pct = 0;  recv_stall_pct = 78; test_random(75, 2);
    send_idle_pct = 19; recv_stall_pct = 19; test_random(75, 4);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_in_if.sv
hw/rtl/bpa_out_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_core.sv
hw/rtl/buddy_page_allocator.sv
tb/sv/buddy_page_allocator_tb.sv
